// ===== rtl/fix_tag_value_field_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the FIX tag=value field decoder.
// ---------------------------------------------------------------------------
`ifndef FIX_TAG_VALUE_FIELD_DECODER_DEFINES_SVH
`define FIX_TAG_VALUE_FIELD_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTVD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder implication check failed");

// The expression must never be true.
`define FTVD_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("decoder forbidden condition seen");

`endif

// ===== rtl/fix_tvd_pkg.sv =====
// ---------------------------------------------------------------------------
// fix_tvd_pkg
// Shared types and constants of the FIX tag=value field decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fix_tvd_pkg;

   // Register file layout.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKSUM_TAG = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_SEP    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_SEP    = 2'd2;

   // Register reset values.
   localparam logic [13:0] RESET_CHECKSUM_TAG = 14'd10;
   localparam logic [7:0]  RESET_VALUE_SEP    = 8'd61;
   localparam logic [7:0]  RESET_FIELD_SEP    = 8'd1;

   // Field widths and limits.
   localparam int TAG_W        = 31;
   localparam int TAG_EXT_W    = 35;
   localparam int LEN_OUT_W    = 16;
   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam logic [TAG_EXT_W-1:0] TAG_MAX = 35'd2147483647;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_TAG   = 2'd0,
      PH_TAIL  = 2'd1,
      PH_VALUE = 2'd2,
      PH_SKIP  = 2'd3
   } phase_type;

   // Live configuration handed from the front to the back.
   typedef struct packed {
      logic [13:0] checksum_tag;
      logic [7:0]  value_sep;
      logic [7:0]  field_sep;
   } cfg_type;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      logic [7:0] data;
      logic       is_fsep;
      logic       is_vsep;
      logic       is_digit;
   } item_type;

   // Queue status seen by the front, the back and the top level.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

// ===== rtl/fix_tag_value_field_decoder.sv =====
// An accepted byte passes the queue and then the output register before it is offered.
// Throughput: one byte per cycle unless the output stalls; the back's parser loop sets it.
// The input stalls only when the two-entry queue is full behind a stalled output.
// Reset is synchronous and active high: parser state, queue and output valid clear,
// and the three configuration registers return to their default values.
// ---------------------------------------------------------------------------
// fix_tag_value_field_decoder
// FIX tag=value stream decoder: reports each value byte, each field's tag and
// lengths, and the checksum sum at the end of each message.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fix_tag_value_field_decoder_defines.svh"

module fix_tag_value_field_decoder #(
   parameter int LENGTH_BITS = fix_tvd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fix_tvd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fix_tvd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_value_byte,
   output logic                                rsp_value_valid,
   output logic                                rsp_field_done,
   output logic [fix_tvd_pkg::TAG_W-1:0]       rsp_field_tag,
   output logic [fix_tvd_pkg::LEN_OUT_W-1:0]   rsp_value_len,
   output logic [fix_tvd_pkg::LEN_OUT_W-1:0]   rsp_raw_len,
   output logic                                rsp_is_checksum_field,
   output logic                                rsp_message_done,
   output logic [7:0]                          rsp_checksum_sum,
   output logic                                rsp_malformed
);
   import fix_tvd_pkg::*;

   cfg_type          cfg;
   queue_status_type q_status;
   item_type         push_item;
   item_type         head_item;
   logic             push;
   logic             pop;

   // Front: configuration and byte classification.
   fix_tvd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .q_status      (q_status),
      .push          (push),
      .push_item     (push_item),
      .cfg           (cfg)
   );

   // Queue between the two halves.
   fix_tvd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // Back: field parser and output register.
   fix_tvd_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .q_status              (q_status),
      .head_item             (head_item),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_value_byte        (rsp_value_byte),
      .rsp_value_valid       (rsp_value_valid),
      .rsp_field_done        (rsp_field_done),
      .rsp_field_tag         (rsp_field_tag),
      .rsp_value_len         (rsp_value_len),
      .rsp_raw_len           (rsp_raw_len),
      .rsp_is_checksum_field (rsp_is_checksum_field),
      .rsp_message_done      (rsp_message_done),
      .rsp_checksum_sum      (rsp_checksum_sum),
      .rsp_malformed         (rsp_malformed)
   );

   // A finished message is always a well-formed field end.
   `FTVD_ASSERT_IMPLIES(a_msg_is_good_field, clock, reset, rsp_valid && rsp_message_done, rsp_field_done && !rsp_malformed)

   // Outside a field end, tag and length fields are zero.
   `FTVD_ASSERT_IMPLIES(a_idle_fields_zero, clock, reset, rsp_valid && !rsp_field_done, rsp_field_tag == 0 && rsp_raw_len == 0 && !rsp_malformed)

   // A byte is never both a value byte and a field separator.
   `FTVD_ASSERT_NEVER(a_value_not_sep, clock, reset, rsp_valid && rsp_value_valid && rsp_field_done)

   // The queue never pops while empty.
   `FTVD_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !q_status.valid)

endmodule

// ===== rtl/fix_tvd_front.sv =====
// ---------------------------------------------------------------------------
// fix_tvd_front
// Holds the configuration registers and classifies each accepted byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fix_tvd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fix_tvd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fix_tvd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                req_valid,
   input  logic [7:0]                          req_data_byte,
   output logic                                req_stall,
   input  fix_tvd_pkg::queue_status_type       q_status,
   output logic                                push,
   output fix_tvd_pkg::item_type               push_item,
   output fix_tvd_pkg::cfg_type                cfg
);
   import fix_tvd_pkg::*;

   logic [13:0] checksum_tag_ff;
   logic [7:0]  value_sep_ff;
   logic [7:0]  field_sep_ff;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         checksum_tag_ff <= RESET_CHECKSUM_TAG;
         value_sep_ff    <= RESET_VALUE_SEP;
         field_sep_ff    <= RESET_FIELD_SEP;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHECKSUM_TAG: checksum_tag_ff <= csr_wdata;
            CSR_VALUE_SEP:    value_sep_ff    <= csr_wdata[7:0];
            CSR_FIELD_SEP:    field_sep_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.checksum_tag = checksum_tag_ff;
   assign cfg.value_sep    = value_sep_ff;
   assign cfg.field_sep    = field_sep_ff;

   // A transfer goes straight into the queue whenever it has room.
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Byte classification against the current separators.
   always_comb begin
      push_item.data     = req_data_byte;
      push_item.is_fsep  = (req_data_byte == field_sep_ff);
      push_item.is_vsep  = (req_data_byte == value_sep_ff);
      push_item.is_digit = (req_data_byte >= ASCII_ZERO) && (req_data_byte <= ASCII_NINE);
   end

endmodule

// ===== rtl/fix_tvd_queue.sv =====
// ---------------------------------------------------------------------------
// fix_tvd_queue
// Short FIFO of classified bytes between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fix_tvd_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  fix_tvd_pkg::item_type         push_item,
   input  logic                          pop,
   output fix_tvd_pkg::item_type         head_item,
   output fix_tvd_pkg::queue_status_type q_status
);
   import fix_tvd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage carries payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = slots_ff[rd_ptr_ff];
   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == FULL_CNT);

endmodule

// ===== rtl/fix_tvd_back.sv =====
// ---------------------------------------------------------------------------
// fix_tvd_back
// Field parser: tracks the tag, value and checksum state one byte per cycle
// unless the output stalls, and holds each result in an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fix_tvd_back #(
   parameter int LENGTH_BITS = fix_tvd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fix_tvd_pkg::cfg_type                cfg,
   input  fix_tvd_pkg::queue_status_type       q_status,
   input  fix_tvd_pkg::item_type               head_item,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_value_byte,
   output logic                                rsp_value_valid,
   output logic                                rsp_field_done,
   output logic [fix_tvd_pkg::TAG_W-1:0]       rsp_field_tag,
   output logic [fix_tvd_pkg::LEN_OUT_W-1:0]   rsp_value_len,
   output logic [fix_tvd_pkg::LEN_OUT_W-1:0]   rsp_raw_len,
   output logic                                rsp_is_checksum_field,
   output logic                                rsp_message_done,
   output logic [7:0]                          rsp_checksum_sum,
   output logic                                rsp_malformed
);
   import fix_tvd_pkg::*;

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   // Parser state.
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [TAG_W-1:0]      tag_ff;
   logic [TAG_W-1:0]      tag_in;
   logic                  digit_seen_ff;
   logic                  digit_seen_in;
   logic [LENGTH_BITS-1:0] value_count_ff;
   logic [LENGTH_BITS-1:0] value_count_in;
   logic [LENGTH_BITS-1:0] raw_count_ff;
   logic [LENGTH_BITS-1:0] raw_count_in;
   logic [7:0]            running_sum_ff;
   logic [7:0]            running_sum_in;
   logic [7:0]            sum_start_ff;
   logic [7:0]            sum_start_in;
   logic                  in_cks_ff;
   logic                  in_cks_in;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [7:0]            value_byte_ff;
   logic [7:0]            value_byte_in;
   logic                  value_valid_ff;
   logic                  value_valid_in;
   logic                  field_done_ff;
   logic                  field_done_in;
   logic [TAG_W-1:0]      field_tag_ff;
   logic [TAG_W-1:0]      field_tag_in;
   logic [LEN_OUT_W-1:0]  value_len_ff;
   logic [LEN_OUT_W-1:0]  value_len_in;
   logic [LEN_OUT_W-1:0]  raw_len_ff;
   logic [LEN_OUT_W-1:0]  raw_len_in;
   logic                  is_cks_ff;
   logic                  is_cks_in;
   logic [7:0]            cks_sum_ff;
   logic [7:0]            cks_sum_in;
   logic                  malformed_ff;
   logic                  malformed_in;

   // Helpers.
   logic                  fire;
   logic [TAG_EXT_W-1:0]  tag_next;
   logic                  tag_ovf;
   logic                  bad;
   logic                  tag_is_cks;
   logic [LEN_OUT_W+LENGTH_BITS-1:0] value_len_ext;
   logic [LEN_OUT_W+LENGTH_BITS-1:0] raw_len_ext;

   // One byte is taken when the output register is free or being drained.
   assign fire = q_status.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = fire;

   // Tag times ten plus the new digit, by shift and add.
   assign tag_next = ({{(TAG_EXT_W-TAG_W){1'b0}}, tag_ff} << 3)
                   + ({{(TAG_EXT_W-TAG_W){1'b0}}, tag_ff} << 1)
                   + {{(TAG_EXT_W-4){1'b0}}, head_item.data[3:0]};
   assign tag_ovf    = (tag_next > TAG_MAX);
   assign tag_is_cks = (tag_ff == {{(TAG_W-14){1'b0}}, cfg.checksum_tag});
   assign bad        = (phase_ff != PH_VALUE);

   // Counts are reported in a 16-bit field whatever their width.
   assign value_len_ext = {{LEN_OUT_W{1'b0}}, value_count_ff};
   assign raw_len_ext   = {{LEN_OUT_W{1'b0}}, raw_count_ff};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (head_item.is_fsep) begin
            phase_in = PH_TAG;
         end else begin
            unique case (phase_ff)
               PH_TAG: begin
                  if (head_item.is_digit) begin
                     if (tag_ovf) begin
                        phase_in = PH_SKIP;
                     end
                  end else if (!digit_seen_ff) begin
                     phase_in = PH_SKIP;
                  end else if (head_item.is_vsep) begin
                     phase_in = PH_VALUE;
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
               PH_TAIL: begin
                  if (head_item.is_vsep) begin
                     phase_in = PH_VALUE;
                  end
               end
               PH_VALUE: phase_in = PH_VALUE;
               PH_SKIP:  phase_in = PH_SKIP;
            endcase
         end
      end
   end

   // Datapath state and result fields.
   always_comb begin
      tag_in         = tag_ff;
      digit_seen_in  = digit_seen_ff;
      value_count_in = value_count_ff;
      raw_count_in   = raw_count_ff;
      running_sum_in = running_sum_ff;
      sum_start_in   = sum_start_ff;
      in_cks_in      = in_cks_ff;

      value_byte_in   = '0;
      value_valid_in  = 1'b0;
      field_done_in   = 1'b0;
      field_tag_in    = '0;
      value_len_in    = '0;
      raw_len_in      = '0;
      is_cks_in       = 1'b0;
      cks_sum_in      = '0;
      malformed_in    = 1'b0;

      if (fire) begin
         // The sum before the field is captured on the field's first byte.
         if (phase_ff == PH_TAG && !digit_seen_ff && raw_count_ff == '0) begin
            sum_start_in = running_sum_ff;
         end
         running_sum_in = running_sum_ff + head_item.data;

         if (head_item.is_fsep) begin
            field_done_in  = 1'b1;
            field_tag_in   = bad ? '0 : tag_ff;
            value_len_in   = bad ? '0 : value_len_ext[LEN_OUT_W-1:0];
            raw_len_in     = raw_len_ext[LEN_OUT_W-1:0];
            malformed_in   = bad;
            if (!bad && in_cks_ff) begin
               is_cks_in      = 1'b1;
               cks_sum_in     = sum_start_in;
               running_sum_in = '0;
               sum_start_in   = '0;
            end
            tag_in         = '0;
            digit_seen_in  = 1'b0;
            value_count_in = '0;
            raw_count_in   = '0;
            in_cks_in      = 1'b0;
         end else begin
            raw_count_in = (raw_count_ff == COUNT_MAX) ? raw_count_ff : raw_count_ff + 1'b1;
            if (phase_ff == PH_VALUE) begin
               value_byte_in  = head_item.data;
               value_valid_in = 1'b1;
               value_count_in = (value_count_ff == COUNT_MAX) ? value_count_ff
                                                              : value_count_ff + 1'b1;
            end else if (phase_ff == PH_TAG) begin
               if (head_item.is_digit) begin
                  if (!tag_ovf) begin
                     tag_in        = tag_next[TAG_W-1:0];
                     digit_seen_in = 1'b1;
                  end
               end else if (digit_seen_ff && head_item.is_vsep) begin
                  in_cks_in = tag_is_cks;
               end
            end else if (phase_ff == PH_TAIL) begin
               if (head_item.is_vsep) begin
                  in_cks_in = tag_is_cks;
               end
            end
         end
      end
   end

   // A result stays until its transfer completes.
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TAG;
         tag_ff         <= '0;
         digit_seen_ff  <= 1'b0;
         value_count_ff <= '0;
         raw_count_ff   <= '0;
         running_sum_ff <= '0;
         sum_start_ff   <= '0;
         in_cks_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         tag_ff         <= tag_in;
         digit_seen_ff  <= digit_seen_in;
         value_count_ff <= value_count_in;
         raw_count_ff   <= raw_count_in;
         running_sum_ff <= running_sum_in;
         sum_start_ff   <= sum_start_in;
         in_cks_ff      <= in_cks_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload is loaded only when a new byte is processed.
   always_ff @(posedge clock) begin
      if (fire) begin
         value_byte_ff   <= value_byte_in;
         value_valid_ff  <= value_valid_in;
         field_done_ff   <= field_done_in;
         field_tag_ff    <= field_tag_in;
         value_len_ff    <= value_len_in;
         raw_len_ff      <= raw_len_in;
         is_cks_ff       <= is_cks_in;
         cks_sum_ff      <= cks_sum_in;
         malformed_ff    <= malformed_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_value_byte        = value_byte_ff;
   assign rsp_value_valid       = value_valid_ff;
   assign rsp_field_done        = field_done_ff;
   assign rsp_field_tag         = field_tag_ff;
   assign rsp_value_len         = value_len_ff;
   assign rsp_raw_len           = raw_len_ff;
   assign rsp_is_checksum_field = is_cks_ff;
   assign rsp_message_done      = is_cks_ff;
   assign rsp_checksum_sum      = cks_sum_ff;
   assign rsp_malformed         = malformed_ff;

endmodule

// ===== verif/fix_tag_value_field_decoder_checker.sv =====
// ---------------------------------------------------------------------------
// fix_tag_value_field_decoder_checker
// Watches the register port and both byte channels of the FIX field decoder.
// It keeps its own copy of the parser state, predicts the outcome of every
// byte taken by the block and compares each returned outcome field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fix_tag_value_field_decoder_checker #(
   parameter int LENGTH_BITS = fix_tvd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fix_tvd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fix_tvd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [7:0]                          rsp_value_byte,
   input  logic                                rsp_value_valid,
   input  logic                                rsp_field_done,
   input  logic [fix_tvd_pkg::TAG_W-1:0]       rsp_field_tag,
   input  logic [fix_tvd_pkg::LEN_OUT_W-1:0]   rsp_value_len,
   input  logic [fix_tvd_pkg::LEN_OUT_W-1:0]   rsp_raw_len,
   input  logic                                rsp_is_checksum_field,
   input  logic                                rsp_message_done,
   input  logic [7:0]                          rsp_checksum_sum,
   input  logic                                rsp_malformed,
   output int unsigned                         error_count,
   output int unsigned                         pending_count
);
   import fix_tvd_pkg::*;

   // Everything the block reports for one byte.
   typedef struct packed {
      logic [7:0]           value_byte;
      logic                 value_valid;
      logic                 field_done;
      logic [TAG_W-1:0]     field_tag;
      logic [LEN_OUT_W-1:0] value_len;
      logic [LEN_OUT_W-1:0] raw_len;
      logic                 is_checksum_field;
      logic                 message_done;
      logic [7:0]           checksum_sum;
      logic                 malformed;
   } byte_outcome_type;

   localparam longint unsigned COUNT_CAP = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam longint unsigned TAG_LIMIT = 64'd2147483647;

   // Configuration as last written.
   logic [13:0]      checksum_tag_cfg;
   logic [7:0]       value_sep_cfg;
   logic [7:0]       field_sep_cfg;

   // Parser state.
   phase_type        parse_phase;
   logic [TAG_W-1:0] tag_value;
   logic             tag_started;
   longint unsigned  value_bytes;
   longint unsigned  field_bytes;
   logic [7:0]       message_sum;
   logic [7:0]       sum_before_field;
   logic             checksum_field_open;

   // Outcomes of bytes taken by the block and not yet returned.
   byte_outcome_type pending_decodes[$];

   initial error_count = 0;
   initial pending_count = 0;

   task automatic note_mismatch(input string msg);
      error_count++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   function automatic longint unsigned saturating_increment(input longint unsigned c);
      return (c >= COUNT_CAP) ? COUNT_CAP : c + 64'd1;
   endfunction

   // The tag is complete: value bytes follow.
   function automatic void start_value();
      parse_phase = PH_VALUE;
      checksum_field_open = (tag_value == checksum_tag_cfg);
   endfunction

   // Advances the parser by one byte and returns what the block should report.
   function automatic byte_outcome_type decode_byte(input logic [7:0] b);
      byte_outcome_type o;
      longint unsigned  tag_wide;
      longint unsigned  grown;
      logic             bad;
      o = '0;
      // The sum of a message is latched when a new field starts.
      if (parse_phase == PH_TAG && !tag_started && field_bytes == 0)
         sum_before_field = message_sum;
      message_sum = message_sum + b;

      if (b == field_sep_cfg) begin
         bad = (parse_phase != PH_VALUE);
         o.field_done = 1'b1;
         o.raw_len    = field_bytes[LEN_OUT_W-1:0];
         o.malformed  = bad;
         if (!bad) begin
            o.field_tag = tag_value;
            o.value_len = value_bytes[LEN_OUT_W-1:0];
            // A well-formed checksum field closes the message.
            if (checksum_field_open) begin
               o.is_checksum_field = 1'b1;
               o.message_done      = 1'b1;
               o.checksum_sum      = sum_before_field;
               message_sum         = 8'd0;
               sum_before_field    = 8'd0;
            end
         end
         parse_phase         = PH_TAG;
         tag_value           = '0;
         tag_started         = 1'b0;
         value_bytes         = 0;
         field_bytes         = 0;
         checksum_field_open = 1'b0;
         return o;
      end

      field_bytes = saturating_increment(field_bytes);
      case (parse_phase)
         PH_VALUE: begin
            o.value_byte  = b;
            o.value_valid = 1'b1;
            value_bytes   = saturating_increment(value_bytes);
         end
         PH_TAG: begin
            if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
               tag_wide = tag_value;
               grown    = tag_wide * 10 + b - 48;
               if (grown > TAG_LIMIT) begin
                  parse_phase = PH_SKIP;
               end else begin
                  tag_value   = grown[TAG_W-1:0];
                  tag_started = 1'b1;
               end
            end else if (!tag_started) begin
               parse_phase = PH_SKIP;
            end else if (b == value_sep_cfg) begin
               start_value();
            end else begin
               parse_phase = PH_TAIL;
            end
         end
         PH_TAIL: begin
            if (b == value_sep_cfg)
               start_value();
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : monitor
      byte_outcome_type seen;
      byte_outcome_type want;
      if (reset) begin
         checksum_tag_cfg    = RESET_CHECKSUM_TAG;
         value_sep_cfg       = RESET_VALUE_SEP;
         field_sep_cfg       = RESET_FIELD_SEP;
         parse_phase         = PH_TAG;
         tag_value           = '0;
         tag_started         = 1'b0;
         value_bytes         = 0;
         field_bytes         = 0;
         message_sum         = 8'd0;
         sum_before_field    = 8'd0;
         checksum_field_open = 1'b0;
         pending_decodes.delete();
      end else begin
         // Register writes must only come while the block is idle; unenforced.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHECKSUM_TAG: checksum_tag_cfg = csr_wdata[13:0];
               CSR_VALUE_SEP:    value_sep_cfg = csr_wdata[7:0];
               CSR_FIELD_SEP:    field_sep_cfg = csr_wdata[7:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall)
            pending_decodes.push_back(decode_byte(req_data_byte));

         // Compare a returned transfer with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            seen.value_byte        = rsp_value_byte;
            seen.value_valid       = rsp_value_valid;
            seen.field_done        = rsp_field_done;
            seen.field_tag         = rsp_field_tag;
            seen.value_len         = rsp_value_len;
            seen.raw_len           = rsp_raw_len;
            seen.is_checksum_field = rsp_is_checksum_field;
            seen.message_done      = rsp_message_done;
            seen.checksum_sum      = rsp_checksum_sum;
            seen.malformed         = rsp_malformed;
            if (pending_decodes.size() == 0) begin
               note_mismatch("result transfer with no byte outstanding");
            end else begin
               want = pending_decodes.pop_front();
               check_field("value_byte", seen.value_byte, want.value_byte);
               check_field("value_valid", seen.value_valid, want.value_valid);
               check_field("field_done", seen.field_done, want.field_done);
               check_field("field_tag", seen.field_tag, want.field_tag);
               check_field("value_len", seen.value_len, want.value_len);
               check_field("raw_len", seen.raw_len, want.raw_len);
               check_field("is_checksum_field", seen.is_checksum_field,
                           want.is_checksum_field);
               check_field("message_done", seen.message_done, want.message_done);
               check_field("checksum_sum", seen.checksum_sum, want.checksum_sum);
               check_field("malformed", seen.malformed, want.malformed);
            end
         end
      end
      pending_count <= pending_decodes.size();
   end

endmodule

// ===== verif/tb_fix_tag_value_field_decoder.sv =====
// ---------------------------------------------------------------------------
// tb_fix_tag_value_field_decoder
// Drives FIX byte streams into the field decoder under several separator and
// checksum tag settings: a short directed stream, then random messages mixed
// with broken fields and noise. Both sides idle at random; a checker predicts
// and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fix_tag_value_field_decoder;
   import fix_tvd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CHECKSUM_TAG;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b1;
   logic [7:0]             rsp_value_byte;
   logic                   rsp_value_valid;
   logic                   rsp_field_done;
   logic [TAG_W-1:0]       rsp_field_tag;
   logic [LEN_OUT_W-1:0]   rsp_value_len;
   logic [LEN_OUT_W-1:0]   rsp_raw_len;
   logic                   rsp_is_checksum_field;
   logic                   rsp_message_done;
   logic [7:0]             rsp_checksum_sum;
   logic                   rsp_malformed;
   int unsigned            error_count;
   int unsigned            pending_count;

   // Stream under construction and the settings it is built for.
   logic [7:0]             stream_bytes[$];
   logic [13:0]            checksum_tag_now = RESET_CHECKSUM_TAG;
   logic [7:0]             value_sep_now = RESET_VALUE_SEP;
   logic [7:0]             field_sep_now = RESET_FIELD_SEP;

   // Idling controls for the sender and for the receiver, and the watchdog's counter.
   bit                     quiet_sender = 1'b0;
   bit                     quiet_receiver = 1'b0;
   int unsigned            stall_hold_cycles = 0;
   int unsigned            cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fix_tag_value_field_decoder dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_value_byte        (rsp_value_byte),
      .rsp_value_valid       (rsp_value_valid),
      .rsp_field_done        (rsp_field_done),
      .rsp_field_tag         (rsp_field_tag),
      .rsp_value_len         (rsp_value_len),
      .rsp_raw_len           (rsp_raw_len),
      .rsp_is_checksum_field (rsp_is_checksum_field),
      .rsp_message_done      (rsp_message_done),
      .rsp_checksum_sum      (rsp_checksum_sum),
      .rsp_malformed         (rsp_malformed)
   );

   fix_tag_value_field_decoder_checker checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_value_byte        (rsp_value_byte),
      .rsp_value_valid       (rsp_value_valid),
      .rsp_field_done        (rsp_field_done),
      .rsp_field_tag         (rsp_field_tag),
      .rsp_value_len         (rsp_value_len),
      .rsp_raw_len           (rsp_raw_len),
      .rsp_is_checksum_field (rsp_is_checksum_field),
      .rsp_message_done      (rsp_message_done),
      .rsp_checksum_sum      (rsp_checksum_sum),
      .rsp_malformed         (rsp_malformed),
      .error_count           (error_count),
      .pending_count         (pending_count)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_fix_tag_value_field_decoder: done, errors");
         $finish;
      end
   end

   // Stream building.
   function automatic void push_text(input string s);
      for (int k = 0; k < s.len(); k++)
         stream_bytes.push_back(s[k]);
   endfunction

   function automatic void push_decimal(input longint unsigned v);
      push_text($sformatf("%0d", v));
   endfunction

   // Value bytes are anything but the field separator.
   function automatic void push_value(input int unsigned n);
      logic [7:0] b;
      repeat (n) begin
         do b = 8'($urandom_range(0, 255)); while (b == field_sep_now);
         stream_bytes.push_back(b);
      end
   endfunction

   function automatic void push_field(input longint unsigned tag, input int unsigned n);
      push_decimal(tag);
      stream_bytes.push_back(value_sep_now);
      push_value(n);
      stream_bytes.push_back(field_sep_now);
   endfunction

   // A few fields followed by the checksum field that closes the message.
   function automatic void push_message();
      longint unsigned tag;
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(0, 9))
            0:       tag = $urandom >> 1;
            1:       tag = 64'd2147483647;
            2:       tag = $urandom_range(0, 9);
            default: tag = $urandom_range(1, 999);
         endcase
         push_field(tag, $urandom_range(0, 6));
      end
      push_decimal(checksum_tag_now);
      stream_bytes.push_back(value_sep_now);
      push_text($sformatf("%03d", $urandom_range(0, 255)));
      stream_bytes.push_back(field_sep_now);
   endfunction

   function automatic void push_broken_field();
      case ($urandom_range(0, 7))
         0: begin
            push_text("-");
            push_field($urandom_range(1, 99), $urandom_range(0, 3));
         end
         1: begin
            push_text("+");
            push_field($urandom_range(1, 99), $urandom_range(0, 3));
         end
         2: begin
            // Value separator where the first tag digit belongs.
            stream_bytes.push_back(value_sep_now);
            push_value($urandom_range(0, 3));
            stream_bytes.push_back(field_sep_now);
         end
         3: stream_bytes.push_back(field_sep_now);
         4: begin
            // Junk after the tag digits; later digits are ignored.
            push_decimal($urandom_range(1, 999));
            push_text("x");
            push_field($urandom_range(0, 99), $urandom_range(0, 3));
         end
         5: begin
            push_decimal($urandom_range(1, 999));
            stream_bytes.push_back(field_sep_now);
         end
         6: push_field(64'd2147483648 + $urandom_range(0, 1000000), 2);
         default: begin
            push_text("00");
            push_field(checksum_tag_now, 3);
         end
      endcase
   endfunction

   // Mostly complete messages, with broken fields and raw noise between.
   function automatic void build_traffic(input int unsigned target);
      while (stream_bytes.size() < target) begin
         case ($urandom_range(0, 9))
            7, 8: push_broken_field();
            9: begin
               repeat ($urandom_range(1, 8))
                  stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: push_message();
         endcase
      end
   endfunction

   function automatic logic [7:0] pick_separator();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b >= ASCII_ZERO && b <= ASCII_NINE);
      return b;
   endfunction

   // Offers the stream one byte per transfer. Starts and ends at a falling edge.
   task automatic send_stream();
      int unsigned gap;
      for (int i = 0; i < stream_bytes.size(); i++) begin
         if (i % 32 == 0)
            quiet_sender = ($urandom_range(0, 2) == 0);
         gap = quiet_sender ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_data_byte = stream_bytes[i];
         req_valid = 1'b1;
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
      req_valid = 1'b0;
      stream_bytes.delete();
   endtask

   // Waits until every byte has come back and the pipeline is empty.
   task automatic settle_decoder();
      req_valid = 1'b0;
      wait (pending_count == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Unused upper data bits of the byte registers carry random values.
   task automatic configure(input logic [13:0] tag, input logic [7:0] vsep,
                            input logic [7:0] fsep);
      logic [5:0] upper;
      write_register(CSR_CHECKSUM_TAG, tag);
      upper = 6'($urandom_range(0, 63));
      write_register(CSR_VALUE_SEP, {upper, vsep});
      upper = 6'($urandom_range(0, 63));
      write_register(CSR_FIELD_SEP, {upper, fsep});
      checksum_tag_now = tag;
      value_sep_now    = vsep;
      field_sep_now    = fsep;
   endtask

   task automatic run_traffic(input int unsigned target);
      build_traffic(target);
      send_stream();
      settle_decoder();
   endtask

   // Receiver: draws a stall length for every transfer it takes.
   initial begin : receiver
      int unsigned wait_cycles;
      int unsigned taken;
      taken = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken % 32 == 0)
            quiet_receiver = ($urandom_range(0, 2) == 0);
         wait_cycles = quiet_receiver ? 0 : $urandom_range(0, 10);
         // A requested long hold-off lets the block fill and stall its input.
         if (stall_hold_cycles != 0) begin
            wait_cycles = stall_hold_cycles;
            stall_hold_cycles = 0;
         end
         if (wait_cycles != 0) begin
            rsp_stall = 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [7:0]  vsep;
      logic [7:0]  fsep;
      logic [13:0] tag;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed stream under the reset settings: value bytes at both extremes,
      // bad first bytes, an empty field, junk after the tag, a missing value
      // separator, a value separator inside a value and an empty checksum field.
      push_text("8=");
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(field_sep_now);
      push_text("-");
      stream_bytes.push_back(field_sep_now);
      push_text("=");
      stream_bytes.push_back(field_sep_now);
      stream_bytes.push_back(field_sep_now);
      push_text("1x2=");
      stream_bytes.push_back(field_sep_now);
      push_text("7");
      stream_bytes.push_back(field_sep_now);
      push_text("9==");
      stream_bytes.push_back(field_sep_now);
      push_text("10=");
      stream_bytes.push_back(field_sep_now);
      send_stream();
      settle_decoder();

      // Random traffic under a series of settings, extremes included.
      for (int s = 0; s < 6; s++) begin
         case (s)
            0: configure(14'd9999, 8'd58, 8'd124);
            1: configure(14'd1, 8'd0, 8'd255);
            2: configure(14'h3FFF, 8'd255, 8'd0);
            3: begin
               // Equal separators: every field ends malformed.
               tag = 14'($urandom_range(1, 9999));
               configure(tag, 8'd35, 8'd35);
            end
            4: begin
               tag  = 14'($urandom_range(1, 9999));
               vsep = pick_separator();
               do fsep = pick_separator(); while (fsep == vsep);
               configure(tag, vsep, fsep);
            end
            default: configure(RESET_CHECKSUM_TAG, RESET_VALUE_SEP,
                               RESET_FIELD_SEP);
         endcase
         if (s == 0)
            stall_hold_cycles = 200;
         run_traffic((s == 3) ? 90 : 150);
      end

      if (error_count == 0)
         $display("tb_fix_tag_value_field_decoder: done, clean");
      else
         $display("tb_fix_tag_value_field_decoder: done, errors");
      $finish;
   end

endmodule
